[rtl/pcpc_pkg.sv]
// Package for the plate color pixel classifier.
// Shared types, register map and fixed constants; no dependencies.
package pcpc_pkg;

    localparam int CH_W   = 8;
    localparam int HUE_W  = 17;   // holds 360 * 255
    localparam int SAT_W  = 15;   // holds 100 * 255
    localparam int BND_W  = 9;
    localparam int FLR_W  = 7;
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = 3;

    typedef logic [CH_W-1:0]  t_chan;
    typedef logic [HUE_W-1:0] t_hue;
    typedef logic [BND_W-1:0] t_bound;
    typedef logic [FLR_W-1:0] t_floor;

    // hue sector constants, degrees
    localparam t_hue HUE_STEP   = 17'd60;
    localparam t_hue HUE_BASE_G = 17'd120;
    localparam t_hue HUE_BASE_B = 17'd240;
    localparam t_hue HUE_WRAP   = 17'd360;
    localparam logic [SAT_W-1:0] SAT_SCALE = 15'd100;

    // register indexes
    localparam logic [IDX_W-1:0] REG_HUE_UPPER        = 3'd0;
    localparam logic [IDX_W-1:0] REG_HUE_LOWER_STRICT = 3'd1;
    localparam logic [IDX_W-1:0] REG_SAT_FLOOR_STRICT = 3'd2;
    localparam logic [IDX_W-1:0] REG_HUE_LOWER_LOOSE  = 3'd3;
    localparam logic [IDX_W-1:0] REG_SAT_FLOOR_LOOSE  = 3'd4;
    localparam logic [IDX_W-1:0] REG_GRAY_SPREAD      = 3'd5;
    localparam logic [IDX_W-1:0] REG_DARK_LIMIT       = 3'd6;

    // reset values
    localparam t_bound RST_HUE_UPPER        = 9'd270;
    localparam t_bound RST_HUE_LOWER_STRICT = 9'd208;
    localparam t_floor RST_SAT_FLOOR_STRICT = 7'd52;
    localparam t_bound RST_HUE_LOWER_LOOSE  = 9'd205;
    localparam t_floor RST_SAT_FLOOR_LOOSE  = 7'd48;
    localparam t_bound RST_GRAY_SPREAD      = 9'd40;
    localparam t_bound RST_DARK_LIMIT       = 9'd80;

    // hue numerator (hue = hnum / delta), delta, max, dark-gray flag
    typedef struct packed {
        t_hue  hnum;
        t_chan delta;
        t_chan mx;
        logic  gray_dark;
    } t_hsv;

endpackage

[rtl/pcpc_if.sv]
// Valid/ready channel interfaces for pixel words and result words.
// Depends on pcpc_pkg.
interface pcpc_pix_if;
    import pcpc_pkg::*;
    logic  valid;
    logic  ready;
    t_chan red;
    t_chan green;
    t_chan blue;
    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

interface pcpc_res_if;
    logic valid;
    logic ready;
    logic color_hit;
    logic text_hit;
    modport source (output valid, color_hit, text_hit, input ready);
    modport sink   (input valid, color_hit, text_hit, output ready);
endinterface

[rtl/pcpc_hsv.sv]
// Max/min, delta, hue numerator and dark near-gray test for one pixel.
// Pure combinational; depends on pcpc_pkg.
module pcpc_hsv (
    input  pcpc_pkg::t_chan  i_red,
    input  pcpc_pkg::t_chan  i_green,
    input  pcpc_pkg::t_chan  i_blue,
    input  pcpc_pkg::t_bound i_gray_spread,
    input  pcpc_pkg::t_bound i_dark_limit,
    output pcpc_pkg::t_hsv   o_hsv
);
    import pcpc_pkg::*;

    t_chan w_mx;
    t_chan w_mn;
    t_chan w_p;
    t_chan w_q;
    t_hue  w_base;
    t_chan w_d_rg;
    t_chan w_d_rb;
    t_chan w_d_bg;
    logic  w_gray;
    logic  w_dark;

    function automatic t_hue HUE_t(input t_chan v);
        HUE_t = {{(HUE_W-CH_W){1'b0}}, v};
    endfunction

    always_comb begin
        w_mx = (i_red > i_green) ? i_red : i_green;
        if (i_blue > w_mx) w_mx = i_blue;
        w_mn = (i_red < i_green) ? i_red : i_green;
        if (i_blue < w_mn) w_mn = i_blue;

        // blue wins ties over green, green over red
        if (i_blue >= i_red && i_blue >= i_green) begin
            w_p    = i_red;
            w_q    = i_green;
            w_base = HUE_BASE_B;
        end else if (i_green >= i_red) begin
            w_p    = i_blue;
            w_q    = i_red;
            w_base = HUE_BASE_G;
        end else begin
            w_p    = i_green;
            w_q    = i_blue;
            w_base = (i_green >= i_blue) ? '0 : HUE_WRAP;
        end

        w_d_rg = (i_red > i_green) ? i_red - i_green : i_green - i_red;
        w_d_rb = (i_red > i_blue)  ? i_red - i_blue  : i_blue - i_red;
        w_d_bg = (i_blue > i_green) ? i_blue - i_green : i_green - i_blue;
        w_gray = ({1'b0, w_d_rg} < i_gray_spread) && ({1'b0, w_d_rb} < i_gray_spread)
              && ({1'b0, w_d_bg} < i_gray_spread);
        w_dark = ({1'b0, i_red} < i_dark_limit) && ({1'b0, i_green} < i_dark_limit)
              && ({1'b0, i_blue} < i_dark_limit);
    end

    assign o_hsv.mx        = w_mx;
    assign o_hsv.delta     = w_mx - w_mn;
    // true result is never negative and fits, so modular arithmetic is exact
    assign o_hsv.hnum      = w_base * HUE_t(w_mx - w_mn) + HUE_STEP * HUE_t(w_p)
                           - HUE_STEP * HUE_t(w_q);
    assign o_hsv.gray_dark = w_gray && w_dark;

endmodule

[rtl/pcpc_window.sv]
// One hue/saturation window test by cross-multiplied compares.
// Pure combinational; depends on pcpc_pkg.
module pcpc_window (
    input  pcpc_pkg::t_hue   i_hnum,
    input  pcpc_pkg::t_chan  i_delta,
    input  pcpc_pkg::t_chan  i_mx,
    input  pcpc_pkg::t_bound i_upper,
    input  pcpc_pkg::t_bound i_lower,
    input  pcpc_pkg::t_floor i_floor,
    output logic             o_hit
);
    import pcpc_pkg::*;

    t_hue              w_up_prod;
    t_hue              w_lo_prod;
    logic [SAT_W-1:0]  w_sat_num;
    logic [SAT_W-1:0]  w_sat_den;

    assign w_up_prod = HUE_W'(i_upper) * HUE_W'(i_delta);
    assign w_lo_prod = HUE_W'(i_lower) * HUE_W'(i_delta);
    assign w_sat_num = SAT_SCALE * SAT_W'(i_delta);
    assign w_sat_den = SAT_W'(i_floor) * SAT_W'(i_mx);

    // a gray pixel (delta zero) fails the strict saturation compare
    assign o_hit = (i_hnum <= w_up_prod) && (i_hnum >= w_lo_prod) && (w_sat_num > w_sat_den);

endmodule

[rtl/plate_color_pixel_classifier_unit.sv]
// Plate color pixel classifier: one RGB pixel word in, one hit word out per clock.
// Top level; depends on pcpc_pkg, pcpc_if, pcpc_hsv and pcpc_window.
//
// Takes one pixel word per clock while the output is not stalled and returns
// its color_hit/text_hit word through the input register, hue/saturation
// register and result register. Sustained rate is one pixel per cycle; each
// stage holds its word and lets the stages ahead of it fill when the output is
// stalled. The hue numerator stage is followed by the window multiply-compare
// stage. Thresholds sit in an APB register file at byte address 4*index;
// write them only while no pixel is in flight.
module plate_color_pixel_classifier_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    pcpc_pix_if.sink                    i_pix,
    pcpc_res_if.source                  o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pcpc_pkg::ADDR_W-1:0] paddr,
    input  logic [pcpc_pkg::DATA_W-1:0] pwdata,
    output logic [pcpc_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import pcpc_pkg::*;

    // configuration
    t_bound r_hue_upper;
    t_bound r_hue_lower_strict;
    t_floor r_sat_floor_strict;
    t_bound r_hue_lower_loose;
    t_floor r_sat_floor_loose;
    t_bound r_gray_spread;
    t_bound r_dark_limit;

    logic             w_wr;
    logic [IDX_W-1:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_upper        <= RST_HUE_UPPER;
            r_hue_lower_strict <= RST_HUE_LOWER_STRICT;
            r_sat_floor_strict <= RST_SAT_FLOOR_STRICT;
            r_hue_lower_loose  <= RST_HUE_LOWER_LOOSE;
            r_sat_floor_loose  <= RST_SAT_FLOOR_LOOSE;
            r_gray_spread      <= RST_GRAY_SPREAD;
            r_dark_limit       <= RST_DARK_LIMIT;
        end else if (w_wr) begin
            case (w_idx)
                REG_HUE_UPPER:        r_hue_upper        <= pwdata[BND_W-1:0];
                REG_HUE_LOWER_STRICT: r_hue_lower_strict <= pwdata[BND_W-1:0];
                REG_SAT_FLOOR_STRICT: r_sat_floor_strict <= pwdata[FLR_W-1:0];
                REG_HUE_LOWER_LOOSE:  r_hue_lower_loose  <= pwdata[BND_W-1:0];
                REG_SAT_FLOOR_LOOSE:  r_sat_floor_loose  <= pwdata[FLR_W-1:0];
                REG_GRAY_SPREAD:      r_gray_spread      <= pwdata[BND_W-1:0];
                REG_DARK_LIMIT:       r_dark_limit       <= pwdata[BND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_HUE_UPPER:        prdata = DATA_W'(r_hue_upper);
            REG_HUE_LOWER_STRICT: prdata = DATA_W'(r_hue_lower_strict);
            REG_SAT_FLOOR_STRICT: prdata = DATA_W'(r_sat_floor_strict);
            REG_HUE_LOWER_LOOSE:  prdata = DATA_W'(r_hue_lower_loose);
            REG_SAT_FLOOR_LOOSE:  prdata = DATA_W'(r_sat_floor_loose);
            REG_GRAY_SPREAD:      prdata = DATA_W'(r_gray_spread);
            REG_DARK_LIMIT:       prdata = DATA_W'(r_dark_limit);
            default:              prdata = '0;
        endcase
    end

    // pipeline control
    logic r_v1, r_v2, r_v3;
    logic w_s1_free, w_s2_free, w_s3_free;

    assign w_s3_free   = !r_v3 || o_res.ready;
    assign w_s2_free   = !r_v2 || w_s3_free;
    assign w_s1_free   = !r_v1 || w_s2_free;
    assign i_pix.ready = w_s1_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_s1_free) r_v1 <= i_pix.valid;
            if (w_s2_free) r_v2 <= r_v1;
            if (w_s3_free) r_v3 <= r_v2;
        end
    end

    // stage 1: input register
    t_chan r_red, r_green, r_blue;

    always_ff @(posedge i_clk) begin
        if (w_s1_free && i_pix.valid) begin
            r_red   <= i_pix.red;
            r_green <= i_pix.green;
            r_blue  <= i_pix.blue;
        end
    end

    // stage 2: hue numerator, delta, max, dark-gray flag
    t_hsv n_s2;
    t_hsv r_s2;

    pcpc_hsv u_hsv (
        .i_red         (r_red),
        .i_green       (r_green),
        .i_blue        (r_blue),
        .i_gray_spread (r_gray_spread),
        .i_dark_limit  (r_dark_limit),
        .o_hsv         (n_s2)
    );

    always_ff @(posedge i_clk) begin
        if (w_s2_free && r_v1) r_s2 <= n_s2;
    end

    // stage 3: window tests into the result register
    logic w_hit_strict, w_hit_loose;
    logic n_color_hit, n_text_hit;
    logic r_color_hit, r_text_hit;

    pcpc_window u_win_strict (
        .i_hnum  (r_s2.hnum),
        .i_delta (r_s2.delta),
        .i_mx    (r_s2.mx),
        .i_upper (r_hue_upper),
        .i_lower (r_hue_lower_strict),
        .i_floor (r_sat_floor_strict),
        .o_hit   (w_hit_strict)
    );

    pcpc_window u_win_loose (
        .i_hnum  (r_s2.hnum),
        .i_delta (r_s2.delta),
        .i_mx    (r_s2.mx),
        .i_upper (r_hue_upper),
        .i_lower (r_hue_lower_loose),
        .i_floor (r_sat_floor_loose),
        .o_hit   (w_hit_loose)
    );

    assign n_color_hit = w_hit_strict || w_hit_loose;
    assign n_text_hit  = n_color_hit || r_s2.gray_dark;

    always_ff @(posedge i_clk) begin
        if (w_s3_free && r_v2) begin
            r_color_hit <= n_color_hit;
            r_text_hit  <= n_text_hit;
        end
    end

    assign o_res.valid     = r_v3;
    assign o_res.color_hit = r_color_hit;
    assign o_res.text_hit  = r_text_hit;

    // checks
    a_text_covers_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (!r_color_hit || r_text_hit))
        else $error("text_hit low while color_hit high");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> r_v1)
        else $error("accepted pixel word lost at stage 1");

    a_empty_s1_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v1 |-> i_pix.ready)
        else $error("input stalled with empty stage 1");

    a_hue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_s2.hnum <= HUE_WRAP * HUE_W'(r_s2.delta)))
        else $error("hue numerator above 360 degrees");

    a_gray_no_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && w_s3_free && r_s2.delta == '0) |=> !r_color_hit)
        else $error("color hit on a pixel with no chroma");

endmodule

[verif/tb_top.sv]
// Testbench for plate_color_pixel_classifier_unit: random and corner pixels, threshold sweeps.
// Depends on pcpc_pkg, pcpc_if and the RTL top level; predicts every hit word in-line.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pcpc_pkg::*;

    localparam int NUM_REGS = 7;
    localparam logic [IDX_W-1:0] REG_PAST_END = 3'd7;   // no register here, writes dropped
    localparam int TIMEOUT_NS = 2_000_000;

    typedef struct packed {
        logic color_hit;
        logic text_hit;
    } t_hit_word;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    pcpc_pix_if pix ();
    pcpc_res_if res ();

    plate_color_pixel_classifier_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    // predictor copy of the threshold registers
    logic [BND_W-1:0] thr [0:NUM_REGS-1];
    t_hit_word hit_q [$];
    int fail_count = 0;
    bit idle_on = 1'b1;
    int hold_left = 0;
    int stall_left = 0;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    function automatic bit in_window(int hnum, int den, int delta, int mx,
                                     int lower, int floor_pct);
        return (hnum <= int'(thr[REG_HUE_UPPER]) * den) && (hnum >= lower * den)
            && (int'(SAT_SCALE) * delta > floor_pct * mx);
    endfunction

    function automatic t_hit_word classify_pixel(int r, int g, int b);
        int mx, mn, delta, hnum, den, spread, dark;
        bit gray;
        t_hit_word w;
        mx = (r > g) ? r : g;
        if (b > mx) mx = b;
        mn = (r < g) ? r : g;
        if (b < mn) mn = b;
        delta = mx - mn;
        if (delta == 0) begin
            hnum = 0;
            den  = 1;
        end else begin
            den = delta;
            // blue beats green beats red on ties
            if (mx == b)
                hnum = int'(HUE_STEP) * (r - g) + int'(HUE_BASE_B) * delta;
            else if (mx == g)
                hnum = int'(HUE_STEP) * (b - r) + int'(HUE_BASE_G) * delta;
            else if (g >= b)
                hnum = int'(HUE_STEP) * (g - b);
            else
                hnum = int'(HUE_STEP) * (g - b) + int'(HUE_WRAP) * delta;
        end
        w.color_hit = in_window(hnum, den, delta, mx, int'(thr[REG_HUE_LOWER_STRICT]),
                                int'(thr[REG_SAT_FLOOR_STRICT]))
                   || in_window(hnum, den, delta, mx, int'(thr[REG_HUE_LOWER_LOOSE]),
                                int'(thr[REG_SAT_FLOOR_LOOSE]));
        spread = int'(thr[REG_GRAY_SPREAD]);
        dark   = int'(thr[REG_DARK_LIMIT]);
        gray = ((r > g ? r - g : g - r) < spread) && ((r > b ? r - b : b - r) < spread)
            && ((b > g ? b - g : g - b) < spread)
            && (r < dark) && (g < dark) && (b < dark);
        w.text_hit = w.color_hit || gray;
        return w;
    endfunction

    // scoreboard: check the result word first, then queue the pixel word's prediction
    always @(posedge i_clk) begin
        t_hit_word want;
        if (i_rst_n && res.valid && res.ready) begin
            if (hit_q.size() == 0) begin
                $display("%0t: result word with none expected: color_hit=%0b text_hit=%0b",
                         $time, res.color_hit, res.text_hit);
                fail_count++;
            end else begin
                want = hit_q.pop_front();
                if (res.color_hit !== want.color_hit) begin
                    $display("%0t: color_hit expected %0b actual %0b",
                             $time, want.color_hit, res.color_hit);
                    fail_count++;
                end
                if (res.text_hit !== want.text_hit) begin
                    $display("%0t: text_hit expected %0b actual %0b",
                             $time, want.text_hit, res.text_hit);
                    fail_count++;
                end
            end
        end
        if (i_rst_n && pix.valid && pix.ready)
            hit_q = {hit_q, classify_pixel(pix.red, pix.green, pix.blue)};
    end

    // result side: long hold-off on request, otherwise random stalls
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            res.ready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            res.ready <= 1'b0;
            stall_left--;
        end else begin
            res.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left = pick_gap();
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Mismatches found");
        $finish;
    end

    task automatic send_pixel(input logic [23:0] rgb);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk) pix.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        pix.valid <= 1'b1;
        pix.red   <= rgb[23:16];
        pix.green <= rgb[15:8];
        pix.blue  <= rgb[7:0];
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
    endtask

    // pause the pixel stream until every result word is back
    task automatic drain();
        @(negedge i_clk) pix.valid <= 1'b0;
        while (hit_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_register(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk) penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < NUM_REGS) begin
            if (idx == REG_SAT_FLOOR_STRICT || idx == REG_SAT_FLOOR_LOOSE)
                thr[idx] = BND_W'(value[FLR_W-1:0]);
            else
                thr[idx] = value[BND_W-1:0];
        end
    endtask

    task automatic set_all(input int upper, input int lo_s, input int fl_s,
                           input int lo_l, input int fl_l, input int spread, input int dark);
        set_register(REG_HUE_UPPER, upper);
        set_register(REG_HUE_LOWER_STRICT, lo_s);
        set_register(REG_SAT_FLOOR_STRICT, fl_s);
        set_register(REG_HUE_LOWER_LOOSE, lo_l);
        set_register(REG_SAT_FLOOR_LOOSE, fl_l);
        set_register(REG_GRAY_SPREAD, spread);
        set_register(REG_DARK_LIMIT, dark);
    endtask

    // mix of uniform, dark near-gray, blue-dominant and saturated-extreme pixels
    function automatic logic [23:0] random_pixel();
        int kind, base;
        logic [7:0] c [3];
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            return 24'($urandom_range(0, 24'hFFFFFF));
        end else if (kind < 60) begin
            base = $urandom_range(0, 110);
            for (int i = 0; i < 3; i++) begin
                int v;
                v = base + $urandom_range(0, 90) - 45;
                c[i] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
            end
            return {c[0], c[1], c[2]};
        end else if (kind < 85) begin
            c[2] = 8'($urandom_range(40, 255));
            c[0] = 8'($urandom_range(0, c[2]));
            c[1] = 8'($urandom_range(0, c[2]));
            return {c[0], c[1], c[2]};
        end else begin
            for (int i = 0; i < 3; i++) begin
                case ($urandom_range(0, 2))
                    0: c[i] = 8'd0;
                    1: c[i] = 8'd255;
                    default: c[i] = 8'($urandom_range(0, 255));
                endcase
            end
            return {c[0], c[1], c[2]};
        end
    endfunction

    task automatic send_random(input int count);
        repeat (count) send_pixel(random_pixel());
    endtask

    task automatic send_corners();
        logic [23:0] corner [18] = '{
            24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
            24'hFFFF00,                 // red/green tie, green wins
            24'h00FFFF,                 // green/blue tie, blue wins
            24'hFF00FF,                 // red/blue tie, blue wins
            24'hFF000A,                 // red sector wrapped to just below 360
            24'h1E3CC8,                 // typical plate blue
            24'h00080F,                 // hue exactly 208
            24'h010002,                 // hue exactly 270
            24'h303064,                 // saturation exactly 52 percent
            24'h4F4F4F, 24'h505050,     // dark limit edges
            24'h002700, 24'h002800,     // gray spread edges
            24'h7F8081
        };
        foreach (corner[i]) send_pixel(corner[i]);
    endtask

    task automatic test_reset_thresholds();
        send_corners();
        send_random(50);
        drain();
    endtask

    task automatic test_threshold_extremes();
        // everything at zero
        set_all(0, 0, 0, 0, 0, 0, 0);
        send_corners();
        send_random(30);
        drain();
        // everything at its top value
        set_all(511, 511, 127, 511, 127, 511, 511);
        send_corners();
        send_random(30);
        drain();
        // wide windows, floors at 100 that nothing can exceed
        set_all(360, 0, 100, 0, 100, 256, 256);
        send_corners();
        send_random(30);
        drain();
        // lower bounds above the upper bound give empty windows
        set_all(200, 201, 0, 360, 0, 1, 1);
        send_corners();
        send_random(30);
        drain();
        // junk above each register's width is dropped, unused address ignored
        set_all(32'hFFFF_FE00 | 270, 32'hFFFF_FE00 | 208, 32'hFFFF_FF80 | 52,
                32'hFFFF_FE00 | 205, 32'hFFFF_FF80 | 48, 32'hFFFF_FE00 | 40,
                32'hFFFF_FE00 | 80);
        set_register(REG_PAST_END, 32'hFFFF_FFFF);
        send_corners();
        send_random(30);
        drain();
    endtask

    task automatic test_random_windows();
        repeat (12) begin
            int upper;
            upper = $urandom_range(0, 360);
            set_all(upper,
                    $urandom_range(0, 1) ? $urandom_range(0, upper) : $urandom_range(0, 360),
                    $urandom_range(0, 100),
                    $urandom_range(0, 1) ? $urandom_range(0, upper) : $urandom_range(0, 360),
                    $urandom_range(0, 100), $urandom_range(0, 256), $urandom_range(0, 256));
            idle_on = ($urandom_range(0, 3) != 0);
            send_random(100);
            drain();
        end
        idle_on = 1'b1;
    endtask

    // result side held off while pixel words keep coming, so the pipeline fills
    task automatic test_output_backpressure();
        set_all(270, 208, 52, 205, 48, 40, 80);
        hold_left = 300;
        send_random(150);
        drain();
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        stall_left = 0;
        send_random(250);
        drain();
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        pix.valid = 1'b0;
        pix.red   = '0;
        pix.green = '0;
        pix.blue  = '0;
        res.ready = 1'b0;
        thr[REG_HUE_UPPER]        = RST_HUE_UPPER;
        thr[REG_HUE_LOWER_STRICT] = RST_HUE_LOWER_STRICT;
        thr[REG_SAT_FLOOR_STRICT] = BND_W'(RST_SAT_FLOOR_STRICT);
        thr[REG_HUE_LOWER_LOOSE]  = RST_HUE_LOWER_LOOSE;
        thr[REG_SAT_FLOOR_LOOSE]  = BND_W'(RST_SAT_FLOOR_LOOSE);
        thr[REG_GRAY_SPREAD]      = RST_GRAY_SPREAD;
        thr[REG_DARK_LIMIT]       = RST_DARK_LIMIT;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_reset_thresholds();
        test_threshold_extremes();
        test_random_windows();
        test_output_backpressure();
        test_back_to_back();

        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
